// ===== src/ptsi_pkg.sv =====
// Package: shared types and constants of the polyline time-slice interpolator.
package ptsi_pkg;

  // Default number of fraction bits in alpha.
  localparam int unsigned FracBitsDefault = 16;

  // Number of entries in the job queue between front and back.
  localparam int unsigned QueueDepth = 2;

  // One bracketing segment, classified by the front and carried out by the back.
  typedef struct packed {
    logic        [31:0] num;     // current time minus time of the lower endpoint
    logic        [31:0] den;     // time of the upper endpoint minus the lower one
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] stamp;
  } job_t;

  // Sequencer states of the back.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_MUL,
    BK_DONE
  } back_state_t;

endpackage

// ===== src/ptsi_front.sv =====
// Front: tracks the previous point of each line and finds the bracketing segment.
module ptsi_front
  import ptsi_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic signed [31:0] current_time,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] point_time,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic               line_end,
  output logic               job_push,
  output job_t               job,
  input  logic               job_full
);

  logic signed [31:0] prev_time;
  logic signed [31:0] prev_x;
  logic signed [31:0] prev_y;
  logic signed [31:0] prev_z;
  logic               have_prev;
  logic               line_done;

  logic               accept;
  logic               fwd;
  logic               bwd;
  logic               emit;
  logic signed [31:0] t_lo;
  logic signed [31:0] t_hi;
  logic        [32:0] num_full;
  logic        [32:0] den_full;

  // A point is taken only while the job queue has room for its result.
  assign full   = job_full;
  assign accept = push && !full;

  // Forward or backward bracket of the current time by this segment.
  always_comb begin
    fwd  = (current_time >= prev_time) && (current_time < point_time);
    bwd  = (current_time >= point_time) && (current_time < prev_time);
    emit = have_prev && !line_done && (fwd || bwd);
    t_lo = fwd ? prev_time : point_time;
    t_hi = fwd ? point_time : prev_time;
    num_full = {current_time[31], current_time} - {t_lo[31], t_lo};
    den_full = {t_hi[31], t_hi} - {t_lo[31], t_lo};
  end

  // Job handed to the back; both differences are non-negative and fit 32 bits.
  always_comb begin
    job.num   = num_full[31:0];
    job.den   = den_full[31:0];
    job.a_x   = fwd ? prev_x : point_x;
    job.a_y   = fwd ? prev_y : point_y;
    job.a_z   = fwd ? prev_z : point_z;
    job.b_x   = fwd ? point_x : prev_x;
    job.b_y   = fwd ? point_y : prev_y;
    job.b_z   = fwd ? point_z : prev_z;
    job.stamp = current_time;
  end

  assign job_push = accept && emit;

  // Line state; the last point of a line clears it after being processed.
  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
      line_done <= 1'b0;
    end else if (accept) begin
      if (line_end) begin
        have_prev <= 1'b0;
        line_done <= 1'b0;
      end else if (!line_done) begin
        have_prev <= 1'b1;
        line_done <= emit;
      end
    end
  end

  // Previous point of the line, kept until the line has emitted.
  always_ff @(posedge clk) begin
    if (accept && !line_done) begin
      prev_time <= point_time;
      prev_x    <= point_x;
      prev_y    <= point_y;
      prev_z    <= point_z;
    end
  end

endmodule

// ===== src/ptsi_job_queue.sv =====
// Job queue: a short first-in first-out store between front and back.
module ptsi_job_queue
  import ptsi_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t head_job,
  output logic empty
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  job_t            entries [QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full     = (count == CntW'(QueueDepth));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

// ===== src/ptsi_back.sv =====
// Back: serial division for alpha, shared multiplier for the three coordinates.
module ptsi_back
  import ptsi_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FracBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_empty,
  input  job_t               job,
  output logic               job_pop,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic signed [31:0] stamp_time
);

  localparam int unsigned CntW  = $clog2(FRAC_BITS);
  localparam int unsigned ProdW = 33 + FRAC_BITS + 1;

  back_state_t state;
  back_state_t state_next;

  logic        [CntW-1:0]      div_cnt;
  logic        [1:0]           mul_step;
  logic        [31:0]          rem;
  logic        [31:0]          den;
  logic        [FRAC_BITS-1:0] alpha;
  logic signed [31:0]          a_x;
  logic signed [31:0]          a_y;
  logic signed [31:0]          a_z;
  logic signed [32:0]          d_x;
  logic signed [32:0]          d_y;
  logic signed [32:0]          d_z;
  logic signed [31:0]          stamp;
  logic signed [31:0]          res_x;
  logic signed [31:0]          res_y;
  logic signed [31:0]          res_z;
  logic signed [ProdW-1:0]     prod;
  logic                        out_valid;

  logic                        load_out;
  logic                        out_free;
  logic        [32:0]          rem_sh;
  logic                        rem_ge;
  logic        [32:0]          rem_sub;
  logic signed [32:0]          mul_d;
  logic signed [31:0]          add_a;
  logic signed [ProdW-1:0]     prod_sh;
  logic signed [31:0]          lerp_val;

  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (!job_empty) state_next = BK_DIV;
      BK_DIV:  if (div_cnt == CntW'(FRAC_BITS - 1)) state_next = BK_MUL;
      BK_MUL:  if (mul_step == 2'd3) state_next = BK_DONE;
      BK_DONE: if (out_free) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    job_pop  = 1'b0;
    load_out = 1'b0;
    unique case (state)
      BK_IDLE: job_pop  = !job_empty;
      BK_DIV:  job_pop  = 1'b0;
      BK_MUL:  job_pop  = 1'b0;
      BK_DONE: load_out = out_free;
      default: job_pop  = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // One restoring division step: the remainder stays below the divisor.
  always_comb begin
    rem_sh  = {rem, 1'b0};
    rem_ge  = (rem_sh >= {1'b0, den});
    rem_sub = rem_sh - {1'b0, den};
  end

  // Coordinate handled by the multiplier, and the one being finished.
  always_comb begin
    case (mul_step)
      2'd0:    mul_d = d_x;
      2'd1:    mul_d = d_y;
      default: mul_d = d_z;
    endcase
    case (mul_step)
      2'd1:    add_a = a_x;
      2'd2:    add_a = a_y;
      default: add_a = a_z;
    endcase
    prod_sh  = prod >>> FRAC_BITS;
    lerp_val = add_a + prod_sh[31:0];
  end

  // Working registers of the back.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt  <= '0;
      mul_step <= '0;
    end else begin
      if (state == BK_IDLE) begin
        div_cnt <= '0;
      end else if (state == BK_DIV) begin
        div_cnt <= div_cnt + 1'b1;
      end
      if (state == BK_MUL) begin
        mul_step <= mul_step + 1'b1;
      end else begin
        mul_step <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      rem   <= job.num;
      den   <= job.den;
      alpha <= '0;
      a_x   <= job.a_x;
      a_y   <= job.a_y;
      a_z   <= job.a_z;
      d_x   <= {job.b_x[31], job.b_x} - {job.a_x[31], job.a_x};
      d_y   <= {job.b_y[31], job.b_y} - {job.a_y[31], job.a_y};
      d_z   <= {job.b_z[31], job.b_z} - {job.a_z[31], job.a_z};
      stamp <= job.stamp;
    end else if (state == BK_DIV) begin
      rem   <= rem_ge ? rem_sub[31:0] : rem_sh[31:0];
      alpha <= {alpha[FRAC_BITS-2:0], rem_ge};
    end
  end

  // Multiply one coordinate per cycle into the product register, then add the lower endpoint to the registered product.
  always_ff @(posedge clk) begin
    if (state == BK_MUL) begin
      if (mul_step != 2'd3) begin
        prod <= ProdW'(mul_d * $signed({1'b0, alpha}));
      end
      case (mul_step)
        2'd1:    res_x <= lerp_val;
        2'd2:    res_y <= lerp_val;
        2'd3:    res_z <= lerp_val;
        default: res_x <= res_x;
      endcase
    end
  end

  // Output register: holds a finished result until it is transferred.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      pos_x      <= res_x;
      pos_y      <= res_y;
      pos_z      <= res_z;
      stamp_time <= stamp;
    end
  end

endmodule

// ===== src/polyline_time_slice_interpolator_core.sv =====
// Top level of the polyline time-slice interpolator.
//
//   channel        handshake                   transfer when
//   points in      push / full                 push && !full
//   results out    empty / pop                 pop && !empty
//   current_time   current_time_wr_en / _data  current_time_wr_en
//
// The front takes one point per cycle while the job queue has room.
// Each line that brackets the current time passes through the back in turn: one
// load, FRAC_BITS steps of the serial divider, the shared multiplier for the
// three coordinates and one handoff to the output register.
// Reset clears all control state and sets current_time to zero.
// A result waiting on the output stalls only the back; points keep arriving
// until the job queue fills, and full then holds the point source off.
module polyline_time_slice_interpolator_core
  import ptsi_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FracBitsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               current_time_wr_en,
  input  logic signed [31:0] current_time_wr_data,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] point_time,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic               line_end,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic signed [31:0] stamp_time
);

  logic signed [31:0] current_time;
  logic               job_push;
  logic               job_full;
  logic               job_pop;
  logic               job_empty;
  job_t               front_job;
  job_t               head_job;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      current_time <= '0;
    end else if (current_time_wr_en) begin
      current_time <= current_time_wr_data;
    end
  end

  ptsi_front u_front (
    .clk          (clk),
    .rst          (rst),
    .current_time (current_time),
    .push         (push),
    .full         (full),
    .point_time   (point_time),
    .point_x      (point_x),
    .point_y      (point_y),
    .point_z      (point_z),
    .line_end     (line_end),
    .job_push     (job_push),
    .job          (front_job),
    .job_full     (job_full)
  );

  ptsi_job_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (front_job),
    .full     (job_full),
    .pop      (job_pop),
    .head_job (head_job),
    .empty    (job_empty)
  );

  ptsi_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .job_empty  (job_empty),
    .job        (head_job),
    .job_pop    (job_pop),
    .empty      (empty),
    .pop        (pop),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .stamp_time (stamp_time)
  );

endmodule

// ===== src/ptsi_checker.sv =====
// Checker: port-level assertions for the interpolator, bound to the top level.
module ptsi_checker (
  input logic               clk,
  input logic               rst,
  input logic               push,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic signed [31:0] pos_x,
  input logic signed [31:0] pos_y,
  input logic signed [31:0] pos_z,
  input logic signed [31:0] stamp_time
);

  logic seen_point;

  // Records whether any point has been transferred since reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_point <= 1'b0;
    end else if (push && !full) begin
      seen_point <= 1'b1;
    end
  end

  // Reset leaves no result on the output.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result shown right after reset");

  // A waiting result stays put until it is transferred.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(pos_x) && $stable(pos_y) &&
                          $stable(pos_z) && $stable(stamp_time)))
    else $error("waiting result changed before its transfer");

  // No result can exist before any point has come in.
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    !empty |-> seen_point)
    else $error("result shown before any point was taken");

  // A result never appears in the cycle straight after the first point.
  a_not_instant: assert property (@(posedge clk) disable iff (rst)
    $rose(seen_point) |-> empty)
    else $error("result shown without passing through the back");

endmodule

bind polyline_time_slice_interpolator_core ptsi_checker u_checker (.*);
